[hdl/tts_pkg.sv]
// ----------------------------------------------------------------------------
// tts_pkg
// Shared constants and controller/datapath interface types for the task
// time-slice scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package tts_pkg;

    localparam int NUM_TASKS = 16;
    localparam int IDX_W     = $clog2(NUM_TASKS);
    localparam int CNT_W     = 16;
    localparam int PRI_W     = 8;
    localparam int IN_W      = 32;
    localparam int OUT_W     = 24;
    localparam int OUT_USR_W = 2;

    // s_tuser codes
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // policy_mode codes
    localparam logic POL_PRIORITY = 1'b0;
    localparam logic POL_SHORTEST = 1'b1;

    typedef logic [IDX_W-1:0] task_idx_t;
    typedef logic [CNT_W-1:0] cnt_t;
    typedef logic [PRI_W-1:0] pri_t;

    typedef struct packed {
        logic start;        // latch task before this item, clear stall
        logic load_wr;      // write one entry from the input item
        logic rd_sel_cur;   // read port on current task, else on scan index
        logic dec_wr;       // decrement counter of current task
        logic scan_init;
        logic scan_step;
        logic refill_init;
        logic refill_step;
        logic take_pick;
        logic set_stall;
        logic out_load;
    } tts_cmd_t;

    typedef struct packed {
        logic cur_zero;
        logic rd_zero;
        logic rd_one;
        logic scan_last;
        logic refill_last;
        logic pick_zero;
        logic helps;
        logic mode;
        logic out_free;
    } tts_sts_t;

endpackage

`default_nettype wire

[hdl/tts_ctrl.sv]
// ----------------------------------------------------------------------------
// tts_ctrl
// Sequencer for load, tick, scan, refill and result delivery.
// ----------------------------------------------------------------------------
`default_nettype none

module tts_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_tvalid,
    input  wire logic              command,
    input  wire tts_pkg::tts_sts_t sts,
    output tts_pkg::tts_cmd_t      cmd,
    output logic                   s_tready
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TICK,
        ST_SCAN,
        ST_SCAN_END,
        ST_REFILL,
        ST_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   second_pass_reg;
    logic   second_pass_next;
    logic   accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        cmd              = '0;
        state_next       = state_reg;
        second_pass_next = second_pass_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.start = 1'b1;
                    if (command == tts_pkg::CMD_LOAD)
                    begin
                        cmd.load_wr = 1'b1;
                        state_next  = ST_FINISH;
                    end
                    else
                    begin
                        state_next = ST_TICK;
                    end
                end
            end
            ST_TICK:
            begin
                cmd.rd_sel_cur   = 1'b1;
                second_pass_next = 1'b0;
                if (sts.cur_zero || sts.rd_zero)
                begin
                    cmd.scan_init = 1'b1;
                    state_next    = ST_SCAN;
                end
                else
                begin
                    cmd.dec_wr = 1'b1;
                    if (sts.rd_one)
                    begin
                        cmd.scan_init = 1'b1;
                        state_next    = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (sts.scan_last)
                begin
                    state_next = ST_SCAN_END;
                end
            end
            ST_SCAN_END:
            begin
                if (!sts.pick_zero)
                begin
                    cmd.take_pick = 1'b1;
                    state_next    = ST_FINISH;
                end
                else if (sts.mode == tts_pkg::POL_SHORTEST || !sts.helps || second_pass_reg)
                begin
                    cmd.set_stall = 1'b1;
                    state_next    = ST_FINISH;
                end
                else
                begin
                    cmd.refill_init = 1'b1;
                    state_next      = ST_REFILL;
                end
            end
            ST_REFILL:
            begin
                cmd.refill_step = 1'b1;
                if (sts.refill_last)
                begin
                    cmd.scan_init    = 1'b1;
                    second_pass_next = 1'b1;
                    state_next       = ST_SCAN;
                end
            end
            ST_FINISH:
            begin
                cmd.rd_sel_cur = 1'b1;
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            second_pass_reg <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            second_pass_reg <= second_pass_next;
        end
    end

    a_one_writer: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load_wr, cmd.dec_wr, cmd.refill_step}))
        else $error("more than one table write source active");

    a_pick_or_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.take_pick && cmd.set_stall))
        else $error("pick and stall in the same cycle");

    a_refill_once: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.refill_init |-> !second_pass_reg)
        else $error("refill started on the second scan pass");

endmodule

`default_nettype wire

[hdl/tts_datapath.sv]
// ----------------------------------------------------------------------------
// tts_datapath
// Task tables, scan unit, refill unit and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module tts_datapath (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire tts_pkg::tts_cmd_t                cmd,
    output tts_pkg::tts_sts_t                     sts,
    input  wire logic                             policy_mode,
    input  wire logic [3:0]                       task_index,
    input  wire tts_pkg::cnt_t                    load_counter,
    input  wire tts_pkg::pri_t                    load_priority,
    input  wire logic                             load_runnable,
    input  wire logic                             m_tready,
    output logic                                  m_tvalid,
    output logic [tts_pkg::OUT_W-1:0]             m_tdata,
    output logic [tts_pkg::OUT_USR_W-1:0]         m_tuser
);

    tts_pkg::cnt_t                      cnt_reg [tts_pkg::NUM_TASKS];
    tts_pkg::pri_t                      pri_reg [tts_pkg::NUM_TASKS];
    logic [tts_pkg::NUM_TASKS-1:0]      run_reg;
    tts_pkg::task_idx_t                 cur_reg;
    tts_pkg::task_idx_t                 before_reg;
    tts_pkg::task_idx_t                 idx_reg;
    tts_pkg::task_idx_t                 pick_reg;
    tts_pkg::cnt_t                      best_reg;
    logic                               helps_reg;
    logic                               stall_reg;
    logic                               m_tvalid_reg;
    logic [tts_pkg::OUT_W-1:0]          m_tdata_reg;
    logic [tts_pkg::OUT_USR_W-1:0]      m_tuser_reg;

    tts_pkg::task_idx_t rd_addr;
    tts_pkg::task_idx_t ld_addr;
    tts_pkg::cnt_t      rd_cnt;
    tts_pkg::pri_t      rd_pri;
    logic               rd_run;
    logic               eligible;
    logic               better;
    logic               ld_in_range;
    tts_pkg::cnt_t      refill_val;

    // single table read port
    assign rd_addr = cmd.rd_sel_cur ? cur_reg : idx_reg;
    assign rd_cnt  = cnt_reg[rd_addr];
    assign rd_pri  = pri_reg[rd_addr];
    assign rd_run  = run_reg[rd_addr];

    assign ld_addr     = tts_pkg::IDX_W'(task_index);
    assign ld_in_range = (int'(task_index) < tts_pkg::NUM_TASKS);

    assign eligible = rd_run && (rd_cnt != '0);
    assign better   = (policy_mode == tts_pkg::POL_SHORTEST)
                    ? ((best_reg == '0) || (rd_cnt < best_reg))
                    : (rd_cnt > best_reg);

    // counter/2 + priority stays below 2^15 + 2^8, no overflow
    assign refill_val = {1'b0, rd_cnt[tts_pkg::CNT_W-1:1]}
                      + tts_pkg::CNT_W'(rd_pri);

    assign sts.cur_zero    = (cur_reg == '0);
    assign sts.rd_zero     = (rd_cnt == '0);
    assign sts.rd_one      = (rd_cnt == tts_pkg::CNT_W'(1));
    assign sts.scan_last   = (policy_mode == tts_pkg::POL_SHORTEST)
                           ? (idx_reg == tts_pkg::IDX_W'(tts_pkg::NUM_TASKS - 1))
                           : (idx_reg == tts_pkg::IDX_W'(1));
    assign sts.refill_last = (idx_reg == tts_pkg::IDX_W'(tts_pkg::NUM_TASKS - 1));
    assign sts.pick_zero   = (pick_reg == '0);
    assign sts.helps       = helps_reg;
    assign sts.mode        = policy_mode;
    assign sts.out_free    = !m_tvalid_reg || m_tready;

    // task tables
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < tts_pkg::NUM_TASKS; i++)
            begin
                cnt_reg[i] <= '0;
                pri_reg[i] <= '0;
            end
            run_reg <= '0;
        end
        else
        begin
            if (cmd.load_wr && ld_in_range)
            begin
                cnt_reg[ld_addr] <= load_counter;
                pri_reg[ld_addr] <= load_priority;
                run_reg[ld_addr] <= load_runnable;
            end
            else if (cmd.dec_wr)
            begin
                cnt_reg[cur_reg] <= rd_cnt - tts_pkg::CNT_W'(1);
            end
            else if (cmd.refill_step)
            begin
                cnt_reg[idx_reg] <= refill_val;
            end
        end
    end

    // scan / refill state and current task
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg    <= '0;
            before_reg <= '0;
            idx_reg    <= '0;
            pick_reg   <= '0;
            best_reg   <= '0;
            helps_reg  <= 1'b0;
            stall_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.start)
            begin
                before_reg <= cur_reg;
                stall_reg  <= 1'b0;
            end
            if (cmd.scan_init)
            begin
                idx_reg   <= (policy_mode == tts_pkg::POL_SHORTEST)
                           ? tts_pkg::IDX_W'(1)
                           : tts_pkg::IDX_W'(tts_pkg::NUM_TASKS - 1);
                pick_reg  <= '0;
                best_reg  <= '0;
                helps_reg <= 1'b0;
            end
            else if (cmd.scan_step)
            begin
                if (eligible && better)
                begin
                    best_reg <= rd_cnt;
                    pick_reg <= idx_reg;
                end
                if (rd_run && (rd_pri != '0))
                begin
                    helps_reg <= 1'b1;
                end
                idx_reg <= (policy_mode == tts_pkg::POL_SHORTEST)
                         ? idx_reg + tts_pkg::IDX_W'(1)
                         : idx_reg - tts_pkg::IDX_W'(1);
            end
            else if (cmd.refill_init)
            begin
                idx_reg <= tts_pkg::IDX_W'(1);
            end
            else if (cmd.refill_step)
            begin
                idx_reg <= idx_reg + tts_pkg::IDX_W'(1);
            end
            if (cmd.take_pick)
            begin
                cur_reg <= pick_reg;
            end
            if (cmd.set_stall)
            begin
                stall_reg <= 1'b1;
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            m_tdata_reg <= tts_pkg::OUT_W'({rd_cnt, 4'(cur_reg)});
            m_tuser_reg <= {stall_reg, (cur_reg != before_reg)};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    a_pick_nonidle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.take_pick |=> (cur_reg != '0))
        else $error("scheduler picked the idle task");

    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!m_tvalid_reg || m_tready))
        else $error("output register overwritten before it was taken");

    a_stall_keeps_task: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.set_stall |=> $stable(cur_reg))
        else $error("current task changed on a stall");

endmodule

`default_nettype wire

[hdl/task_timeslice_scheduler.sv]
// ----------------------------------------------------------------------------
// task_timeslice_scheduler
// Counter-driven task scheduler with per-task counter, priority and runnable
// bit, priority or shortest-first selection, and a halving refill pass.
// ----------------------------------------------------------------------------
// Usage: items enter on s_* (s_tuser = command: load or tick) and one result
// item leaves on m_* for each input item. policy_mode is written through
// cfg_wr_en/cfg_wr_data; the user must write it only while the block is idle,
// which the block itself does not enforce. One item is in work at a time;
// s_tready is high only when the sequencer is idle. A load writes its entry
// on acceptance and goes straight to the finish state. A tick without a
// schedule decrements the current task's counter; a schedule adds one scan of
// NUM_TASKS-1 entries through the single table read port (one entry a cycle)
// plus a decision step; a priority-mode refill adds a refill sweep and a
// second scan. The result sits in an output register; a stalled receiver
// holds it there and the block finishes the next item up to its final
// cycle, then waits until the register frees. Reset clears all task entries,
// the current task (idle task 0) and policy_mode.
// ----------------------------------------------------------------------------
`default_nettype none

module task_timeslice_scheduler (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic        cfg_wr_data,  // policy_mode
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,      // task_index, load_counter, load_priority,
                                           // load_runnable
    input  wire logic        s_tuser,      // command
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,      // running_task, running_counter
    output logic [1:0]       m_tuser       // switched, stalled
);

    tts_pkg::tts_cmd_t cmd;
    tts_pkg::tts_sts_t sts;
    logic              policy_mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_mode_reg <= tts_pkg::POL_PRIORITY;
        end
        else if (cfg_wr_en)
        begin
            policy_mode_reg <= cfg_wr_data;
        end
    end

    tts_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .command  (s_tuser),
        .sts      (sts),
        .cmd      (cmd),
        .s_tready (s_tready)
    );

    tts_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .policy_mode   (policy_mode_reg),
        .task_index    (s_tdata[3:0]),
        .load_counter  (s_tdata[19:4]),
        .load_priority (s_tdata[27:20]),
        .load_runnable (s_tdata[28]),
        .m_tready      (m_tready),
        .m_tvalid      (m_tvalid),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser)
    );

endmodule

`default_nettype wire
